### rtl/cln_pkg.sv
// Shared types and constants for the character LCD nibble writer.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package cln_pkg;

    // Request operation codes.
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_RAW    = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_NUMBER = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;
    localparam logic [2:0] OP_SHIFT  = 3'd6;

    // Register-select values on the LCD bus.
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Row and shift direction codes that produce output.
    localparam logic [1:0] ROW_ONE   = 2'd1;
    localparam logic [1:0] ROW_TWO   = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // Longest burst of nibbles that one request can cause.
    localparam int MAX_NIBBLES = 11;

    // Display RAM base addresses of the two rows.
    localparam logic [7:0] ROW_ONE_BASE = 8'h80;
    localparam logic [7:0] ROW_TWO_BASE = 8'hC0;

    // Command nibbles of the clear and shift pairs.
    localparam logic [3:0] CLEAR_HI     = 4'h0;
    localparam logic [3:0] CLEAR_LO     = 4'h1;
    localparam logic [3:0] SHIFT_HI     = 4'h1;
    localparam logic [3:0] SHIFT_LEFT_LO  = 4'hC;
    localparam logic [3:0] SHIFT_RIGHT_LO = 4'h8;

    // Number printing: saturation limit and the character codes used.
    localparam logic [12:0] NUM_LIMIT  = 13'd5999;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;

    typedef logic [3:0] nibble_t;
    typedef logic [3:0] count_t;
    typedef logic [MAX_NIBBLES-1:0][3:0] nibble_vec_t;

    // Power-up wake-up sequence for 4-bit mode; entry 0 goes out first.
    localparam nibble_vec_t WAKE_SEQ = {
        4'h6, 4'h0, 4'hC, 4'h0, 4'hC, 4'h2, 4'h2, 4'h3, 4'h3, 4'h3, 4'h0
    };

    // Captured request, with the number already reduced to sign and magnitude.
    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  command_nibble;
        logic [7:0]  char_code;
        logic        negative;
        logic [12:0] magnitude;
        logic [1:0]  row_select;
        logic [5:0]  column_select;
        logic [1:0]  shift_direction;
    } request_t;

    // One decoded burst: a common register select and up to eleven nibbles.
    typedef struct packed {
        logic        register_select;
        count_t      count;
        nibble_vec_t nibbles;
    } burst_t;

endpackage

### rtl/cln_capture.sv
// Request input register of the LCD nibble writer.
// Depends on cln_pkg; folds the signed number into sign and saturated magnitude.
module cln_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [2:0]          operation,
    input  logic [3:0]          command_nibble,
    input  logic [7:0]          char_code,
    input  logic signed [13:0]  number_value,
    input  logic [1:0]          row_select,
    input  logic [5:0]          column_select,
    input  logic [1:0]          shift_direction,
    input  logic                take,
    output logic                req_valid,
    output cln_pkg::request_t   req
);

    logic              req_valid_reg;
    logic              req_valid_next;
    cln_pkg::request_t req_reg;
    cln_pkg::request_t req_next;
    logic              accept;
    logic              negative;
    logic [13:0]       magnitude_full;

    // The register holds while the burst stage has not taken its content.
    assign item_stall = req_valid_reg & ~take;
    assign accept     = item_valid & ~item_stall;

    // Sign and magnitude with saturation at the printable limit.
    always_comb
    begin
        negative       = number_value[13];
        magnitude_full = negative ? (14'd0 - number_value) : number_value;
        req_next                 = req_reg;
        req_next.operation       = operation;
        req_next.command_nibble  = command_nibble;
        req_next.char_code       = char_code;
        req_next.negative        = negative;
        req_next.magnitude       = (magnitude_full > {1'b0, cln_pkg::NUM_LIMIT})
                                   ? cln_pkg::NUM_LIMIT : magnitude_full[12:0];
        req_next.row_select      = row_select;
        req_next.column_select   = column_select;
        req_next.shift_direction = shift_direction;
    end

    // Valid flag: set on a transfer, cleared when the burst stage takes it.
    always_comb
    begin
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (take)
        begin
            req_valid_next = 1'b0;
        end
        else
        begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    // Payload register, loaded only on a transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    // A held request that is not taken stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !take |=> req_valid_reg)
        else $error("held request was dropped");

    // The stored magnitude never exceeds the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> req_reg.magnitude <= cln_pkg::NUM_LIMIT)
        else $error("magnitude above saturation limit");

endmodule

### rtl/cln_decode.sv
// Burst decoder of the LCD nibble writer: one request to its nibble list.
// Depends on cln_pkg; purely combinational, between the request and burst registers.
module cln_decode (
    input  cln_pkg::request_t req,
    output cln_pkg::burst_t   burst
);

    logic [2:0]       q3;
    logic [9:0]       r3;
    logic [3:0]       q2;
    logic [6:0]       r2;
    logic [3:0]       q1;
    logic [3:0]       q0;
    logic [3:0][3:0]  digits;
    logic [2:0]       ndig;
    logic [2:0]       nchars;
    logic [2:0]       pos;
    logic [1:0]       dig_idx;
    logic [4:0][7:0]  chars;
    logic [7:0]       address;
    logic [7:0]       base;

    // Decimal digits by parallel compares against multiples of each power of ten.
    always_comb
    begin
        q3 = 3'd0;
        for (int k = 1; k <= 5; k++)
        begin
            if (req.magnitude >= 13'(k * 1000))
            begin
                q3 = 3'(k);
            end
        end
        r3 = 10'(req.magnitude - 13'(q3) * 13'd1000);
        q2 = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (r3 >= 10'(k * 100))
            begin
                q2 = 4'(k);
            end
        end
        r2 = 7'(r3 - 10'(q2) * 10'd100);
        q1 = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (r2 >= 7'(k * 10))
            begin
                q1 = 4'(k);
            end
        end
        q0 = 4'(r2 - 7'(q1) * 7'd10);
        digits = {{1'b0, q3}, q2, q1, q0};
    end

    // Character list of a number: optional minus, then digits with no leading zeros.
    always_comb
    begin
        if (req.magnitude >= 13'd1000)
        begin
            ndig = 3'd4;
        end
        else if (req.magnitude >= 13'd100)
        begin
            ndig = 3'd3;
        end
        else if (req.magnitude >= 13'd10)
        begin
            ndig = 3'd2;
        end
        else
        begin
            ndig = 3'd1;
        end
        nchars  = ndig + {2'b00, req.negative};
        pos     = 3'd0;
        dig_idx = 2'd0;
        for (int j = 0; j < 5; j++)
        begin
            chars[j] = cln_pkg::CHAR_ZERO;
            if (req.negative && (j == 0))
            begin
                chars[j] = cln_pkg::CHAR_MINUS;
            end
            else
            begin
                pos = 3'(j) - {2'b00, req.negative};
                if (pos < ndig)
                begin
                    dig_idx  = 2'(ndig - 3'd1 - pos);
                    chars[j] = cln_pkg::CHAR_ZERO + {4'b0000, digits[dig_idx]};
                end
            end
        end
    end

    // Cursor address: row base plus column minus one, wrapping at eight bits.
    always_comb
    begin
        base    = (req.row_select == cln_pkg::ROW_TWO)
                  ? cln_pkg::ROW_TWO_BASE : cln_pkg::ROW_ONE_BASE;
        address = base + {2'b00, req.column_select} - 8'd1;
    end

    // Burst assembly per operation.
    always_comb
    begin
        burst.register_select = cln_pkg::RS_COMMAND;
        burst.count           = 4'd0;
        burst.nibbles         = '0;
        unique case (req.operation)
            cln_pkg::OP_INIT:
            begin
                burst.count   = 4'(cln_pkg::MAX_NIBBLES);
                burst.nibbles = cln_pkg::WAKE_SEQ;
            end
            cln_pkg::OP_RAW:
            begin
                burst.count      = 4'd1;
                burst.nibbles[0] = req.command_nibble;
            end
            cln_pkg::OP_CHAR:
            begin
                burst.register_select = cln_pkg::RS_DATA;
                burst.count           = 4'd2;
                burst.nibbles[0]      = req.char_code[7:4];
                burst.nibbles[1]      = req.char_code[3:0];
            end
            cln_pkg::OP_NUMBER:
            begin
                burst.register_select = cln_pkg::RS_DATA;
                burst.count           = {nchars, 1'b0};
                for (int j = 0; j < 5; j++)
                begin
                    burst.nibbles[2*j]   = chars[j][7:4];
                    burst.nibbles[2*j+1] = chars[j][3:0];
                end
            end
            cln_pkg::OP_CURSOR:
            begin
                if ((req.row_select == cln_pkg::ROW_ONE) ||
                    (req.row_select == cln_pkg::ROW_TWO))
                begin
                    burst.count      = 4'd2;
                    burst.nibbles[0] = address[7:4];
                    burst.nibbles[1] = address[3:0];
                end
            end
            cln_pkg::OP_CLEAR:
            begin
                burst.count      = 4'd2;
                burst.nibbles[0] = cln_pkg::CLEAR_HI;
                burst.nibbles[1] = cln_pkg::CLEAR_LO;
            end
            cln_pkg::OP_SHIFT:
            begin
                if (req.shift_direction == cln_pkg::DIR_LEFT)
                begin
                    burst.count      = 4'd2;
                    burst.nibbles[0] = cln_pkg::SHIFT_HI;
                    burst.nibbles[1] = cln_pkg::SHIFT_LEFT_LO;
                end
                else if (req.shift_direction == cln_pkg::DIR_RIGHT)
                begin
                    burst.count      = 4'd2;
                    burst.nibbles[0] = cln_pkg::SHIFT_HI;
                    burst.nibbles[1] = cln_pkg::SHIFT_RIGHT_LO;
                end
            end
            default:
            begin
                burst.count = 4'd0;
            end
        endcase
    end

endmodule

### rtl/cln_emit.sv
// Burst register and nibble output of the LCD nibble writer.
// Depends on cln_pkg; shifts one nibble out per output transfer.
module cln_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  cln_pkg::burst_t   burst_in,
    output logic              take,
    output logic              nibble_valid,
    input  logic              nibble_stall,
    output logic              register_select,
    output logic [3:0]        bus_nibble,
    output logic              last_nibble
);

    cln_pkg::count_t      count_reg;
    cln_pkg::count_t      count_next;
    cln_pkg::nibble_vec_t nibbles_reg;
    cln_pkg::nibble_vec_t nibbles_next;
    logic                 rs_reg;
    logic                 rs_next;
    logic                 out_xfer;
    logic                 load_ready;
    logic                 load;

    assign nibble_valid    = (count_reg != 4'd0);
    assign register_select = rs_reg;
    assign bus_nibble      = nibbles_reg[0];
    assign last_nibble     = (count_reg == 4'd1);

    // A new burst loads when the register is empty or its final nibble leaves now.
    assign out_xfer   = nibble_valid & ~nibble_stall;
    assign load_ready = (count_reg == 4'd0) | ((count_reg == 4'd1) & out_xfer);
    assign load       = req_valid & load_ready;
    assign take       = load_ready;

    // Next burst state: load, shift by one nibble, or hold.
    always_comb
    begin
        count_next   = count_reg;
        nibbles_next = nibbles_reg;
        rs_next      = rs_reg;
        if (load)
        begin
            count_next   = burst_in.count;
            nibbles_next = burst_in.nibbles;
            rs_next      = burst_in.register_select;
        end
        else if (out_xfer)
        begin
            count_next   = count_reg - 4'd1;
            nibbles_next = {4'h0, nibbles_reg[cln_pkg::MAX_NIBBLES-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nibbles_reg <= nibbles_next;
        rs_reg      <= rs_next;
    end

    // The burst length never exceeds the longest sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'(cln_pkg::MAX_NIBBLES))
        else $error("burst count out of range");

    // A new burst only replaces an empty or just-finished one.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == 4'd0) || (last_nibble && out_xfer))
        else $error("burst overwritten before it was sent");

    // After the final transfer with nothing loaded, the output goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        last_nibble && out_xfer && !load |=> !nibble_valid)
        else $error("output stayed valid after the final nibble");

endmodule

### rtl/char_lcd_nibble_writer.sv
// A request's first nibble reaches the outputs through the request register, then the
// burst register; the next burst loads as the final nibble of the last one leaves.
// Throughput: each request causes up to eleven nibbles (eleven for init), which leave
// on the single nibble output, one transfer per cycle while nibble_stall is low.
// Reset: rst_n clears the request and burst valid state asynchronously; no outputs pend.
// Depends on cln_pkg, cln_capture, cln_decode and cln_emit.
module char_lcd_nibble_writer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         operation,
    input  logic [3:0]         command_nibble,
    input  logic [7:0]         char_code,
    input  logic signed [13:0] number_value,
    input  logic [1:0]         row_select,
    input  logic [5:0]         column_select,
    input  logic [1:0]         shift_direction,
    output logic               nibble_valid,
    input  logic               nibble_stall,
    output logic               register_select,
    output logic [3:0]         bus_nibble,
    output logic               last_nibble
);

    logic              req_valid;
    logic              take;
    cln_pkg::request_t req;
    cln_pkg::burst_t   burst;

    // Request register.
    cln_capture u_capture (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .operation       (operation),
        .command_nibble  (command_nibble),
        .char_code       (char_code),
        .number_value    (number_value),
        .row_select      (row_select),
        .column_select   (column_select),
        .shift_direction (shift_direction),
        .take            (take),
        .req_valid       (req_valid),
        .req             (req)
    );

    // Request to nibble burst.
    cln_decode u_decode (
        .req   (req),
        .burst (burst)
    );

    // Burst register and output.
    cln_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .burst_in        (burst),
        .take            (take),
        .nibble_valid    (nibble_valid),
        .nibble_stall    (nibble_stall),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .last_nibble     (last_nibble)
    );

endmodule
